[rtl/core/rbsht_pkg.sv]
// Shared constants and types for the ray/box slab hit test.
`default_nettype none
package rbsht_pkg;
   localparam int DEF_COORD_WIDTH = 32;
   localparam int DEF_FRAC_BITS = 16;
   localparam int T_WIDTH = 64;
   localparam logic [T_WIDTH-1:0] T_MAX = {1'b0, {(T_WIDTH-1){1'b1}}};
   localparam logic [T_WIDTH-1:0] T_MIN = {1'b1, {(T_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic signed [T_WIDTH-1:0] t_lo;
      logic signed [T_WIDTH-1:0] t_hi;
      logic                      dir_zero;
      logic                      in_slab;
   } lane_res_type;
endpackage
`default_nettype wire

[rtl/core/rbsht_lane.sv]
// One axis lane: two pipelined restoring dividers and the ordering of t0 and t1.
`default_nettype none
module rbsht_lane
   import rbsht_pkg::*;
#(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic signed [COORD_WIDTH-1:0] mn,
   input  wire logic signed [COORD_WIDTH-1:0] mx,
   input  wire logic signed [COORD_WIDTH-1:0] org,
   input  wire logic signed [COORD_WIDTH-1:0] dir,
   output lane_res_type                       res
);
   localparam int CW = COORD_WIDTH;
   localparam int QW = COORD_WIDTH + FRAC_BITS;
   localparam int EW = (QW > T_WIDTH) ? QW : T_WIDTH;

   // per-stage state of both dividers, index 0 is the input register
   logic [CW-1:0] r0_ff [0:QW];
   logic [CW-1:0] r1_ff [0:QW];
   logic [QW-1:0] n0_ff [0:QW];
   logic [QW-1:0] n1_ff [0:QW];
   logic [QW-1:0] q0_ff [0:QW];
   logic [QW-1:0] q1_ff [0:QW];
   logic [CW-1:0] dm_ff [0:QW];
   logic [QW:0]   neg0_ff, neg1_ff, zero_ff, pass_ff;

   logic [CW:0]   d0_in, d1_in, dm_in;
   logic          nn0_in, nn1_in, dn_in;

   always_comb begin
      nn0_in = mn < org;
      nn1_in = mx < org;
      dn_in  = dir[CW-1];
      d0_in  = nn0_in ? ({org[CW-1], org} - {mn[CW-1], mn})
                      : ({mn[CW-1], mn} - {org[CW-1], org});
      d1_in  = nn1_in ? ({org[CW-1], org} - {mx[CW-1], mx})
                      : ({mx[CW-1], mx} - {org[CW-1], org});
      dm_in  = dn_in ? ((CW+1)'(0) - {dir[CW-1], dir}) : {dir[CW-1], dir};
   end

   // capture magnitudes and signs
   always_ff @(posedge clock) begin
      if (en) begin
         r0_ff[0]   <= '0;
         r1_ff[0]   <= '0;
         q0_ff[0]   <= '0;
         q1_ff[0]   <= '0;
         n0_ff[0]   <= QW'(d0_in[CW-1:0]) << FRAC_BITS;
         n1_ff[0]   <= QW'(d1_in[CW-1:0]) << FRAC_BITS;
         dm_ff[0]   <= dm_in[CW-1:0];
         neg0_ff[0] <= nn0_in ^ dn_in;
         neg1_ff[0] <= nn1_in ^ dn_in;
         zero_ff[0] <= dir == '0;
         pass_ff[0] <= (mn < org) && (org < mx);
      end
   end

   // one quotient bit per stage
   for (genvar s = 0; s < QW; s++) begin : g_step
      logic [CW:0] sh0, sh1;
      logic        ge0, ge1;
      always_comb begin
         sh0 = {r0_ff[s], n0_ff[s][QW-1]};
         sh1 = {r1_ff[s], n1_ff[s][QW-1]};
         ge0 = sh0 >= {1'b0, dm_ff[s]};
         ge1 = sh1 >= {1'b0, dm_ff[s]};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            r0_ff[s+1]   <= ge0 ? CW'(sh0 - {1'b0, dm_ff[s]}) : CW'(sh0);
            r1_ff[s+1]   <= ge1 ? CW'(sh1 - {1'b0, dm_ff[s]}) : CW'(sh1);
            n0_ff[s+1]   <= n0_ff[s] << 1;
            n1_ff[s+1]   <= n1_ff[s] << 1;
            q0_ff[s+1]   <= {q0_ff[s][QW-2:0], ge0};
            q1_ff[s+1]   <= {q1_ff[s][QW-2:0], ge1};
            dm_ff[s+1]   <= dm_ff[s];
            neg0_ff[s+1] <= neg0_ff[s];
            neg1_ff[s+1] <= neg1_ff[s];
            zero_ff[s+1] <= zero_ff[s];
            pass_ff[s+1] <= pass_ff[s];
         end
      end
   end

   // saturate, apply sign and order the pair
   logic [EW-1:0]             qe0, qe1;
   logic [T_WIDTH-1:0]        m0, m1;
   logic signed [T_WIDTH-1:0] t0, t1;
   lane_res_type              res_ff, res_in;

   always_comb begin
      qe0 = EW'(q0_ff[QW]);
      qe1 = EW'(q1_ff[QW]);
      m0  = (qe0 > EW'(T_MAX)) ? T_MAX : T_WIDTH'(qe0);
      m1  = (qe1 > EW'(T_MAX)) ? T_MAX : T_WIDTH'(qe1);
      t0  = neg0_ff[QW] ? -$signed(m0) : $signed(m0);
      t1  = neg1_ff[QW] ? -$signed(m1) : $signed(m1);
      res_in.t_lo     = (t1 < t0) ? t1 : t0;
      res_in.t_hi     = (t1 < t0) ? t0 : t1;
      res_in.dir_zero = zero_ff[QW];
      res_in.in_slab  = pass_ff[QW];
   end

   always_ff @(posedge clock) begin
      if (en) res_ff <= res_in;
   end

   assign res = res_ff;
endmodule
`default_nettype wire

[rtl/core/rbsht_merge.sv]
// Merge of the three lanes: largest entry, smallest exit, hit register.
`default_nettype none
module rbsht_merge
   import rbsht_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         en,
   input  wire lane_res_type lane_x,
   input  wire lane_res_type lane_y,
   input  wire lane_res_type lane_z,
   output logic              hit
);
   lane_res_type              ln [3];
   logic signed [T_WIDTH-1:0] entry, exitv;
   logic                      miss;
   logic                      hit_ff, hit_in;

   always_comb begin
      ln[0] = lane_x;
      ln[1] = lane_y;
      ln[2] = lane_z;
      entry = $signed(T_MIN);
      exitv = $signed(T_MAX);
      miss  = 1'b0;
      for (int a = 0; a < 3; a++) begin
         if (ln[a].dir_zero) begin
            if (!ln[a].in_slab) miss = 1'b1;
         end else begin
            if (entry < ln[a].t_lo) entry = ln[a].t_lo;
            if (ln[a].t_hi < exitv) exitv = ln[a].t_hi;
         end
      end
      hit_in = !miss && (entry < exitv);
   end

   always_ff @(posedge clock) begin
      if (en) hit_ff <= hit_in;
   end

   assign hit = hit_ff;
endmodule
`default_nettype wire

[rtl/core/ray_box_slab_hit_test.sv]
// Top level of the ray/box slab hit test.
// Usage:
//  - req_ channel carries one beat per test: box corners, ray origin and
//    direction, all signed fixed point (COORD_WIDTH bits, FRAC_BITS fraction).
//  - rsp_ channel returns one beat per request, rsp_hit, in request order.
//  - Three axis lanes run side by side; each divides both slab distances by
//    the direction in a restoring divider that yields one quotient bit per
//    stage, then orders the pair. A merge stage takes the largest entry and
//    smallest exit and registers the verdict.
//  - Path: each beat passes the lane input register, one divider stage per
//    quotient bit, the lane ordering register and the merge hit register.
//  - Throughput: one beat per cycle; a new request is taken every cycle
//    while the result register is empty or being drained.
//  - When the receiver stalls, the whole pipeline holds and req_ready drops;
//    it resumes as soon as the waiting beat is taken.
//  - Reset (synchronous, active high) drops all beats in flight; payload
//    registers are left as they are.
`default_nettype none
module ray_box_slab_hit_test
   import rbsht_pkg::*;
#(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [COORD_WIDTH-1:0] req_box_min_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_box_min_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_box_min_z,
   input  wire logic signed [COORD_WIDTH-1:0] req_box_max_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_box_max_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_box_max_z,
   input  wire logic signed [COORD_WIDTH-1:0] req_ray_origin_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_ray_origin_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_ray_origin_z,
   input  wire logic signed [COORD_WIDTH-1:0] req_ray_dir_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_ray_dir_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_ray_dir_z,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_hit
);
   // input register, one stage per quotient bit, ordering register
   localparam int LANE_LAT = COORD_WIDTH + FRAC_BITS + 2;

   logic                en;
   logic [LANE_LAT-1:0] vld_ff;
   logic                rsp_valid_ff;
   lane_res_type        res_x, res_y, res_z;

   // advance everything unless a finished beat is stuck at the output
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[LANE_LAT-2:0], req_valid};
         rsp_valid_ff <= vld_ff[LANE_LAT-1];
      end
   end

   rbsht_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane_x (
      .clock(clock), .en(en), .mn(req_box_min_x), .mx(req_box_max_x),
      .org(req_ray_origin_x), .dir(req_ray_dir_x), .res(res_x));
   rbsht_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane_y (
      .clock(clock), .en(en), .mn(req_box_min_y), .mx(req_box_max_y),
      .org(req_ray_origin_y), .dir(req_ray_dir_y), .res(res_y));
   rbsht_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane_z (
      .clock(clock), .en(en), .mn(req_box_min_z), .mx(req_box_max_z),
      .org(req_ray_origin_z), .dir(req_ray_dir_z), .res(res_z));

   rbsht_merge u_merge (
      .clock(clock), .en(en), .lane_x(res_x), .lane_y(res_y), .lane_z(res_z),
      .hit(rsp_hit));

   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

[rtl/core/rbsht_checker.sv]
// Port-level checks for the ray/box slab hit test, bound to the top level.
`default_nettype none
module rbsht_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_hit
);
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat shown right after reset");
   a_ready_follows_out: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not track the output register");
   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit))
      else $error("stalled result beat changed or vanished");
endmodule

bind ray_box_slab_hit_test rbsht_checker u_rbsht_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_hit(rsp_hit));
`default_nettype wire

[test/tb_top.sv]
// Self-checking bench for the ray/box slab hit test: queued stimulus, local predictor.
`default_nettype none
module tb_top;
   import rbsht_pkg::*;

   localparam int CW = DEF_COORD_WIDTH;
   localparam int FB = DEF_FRAC_BITS;
   localparam int LATENCY = CW + FB + 2;
   localparam int IDLE_LIMIT = 20000;
   localparam int N_RANDOM = 2000;

   typedef logic signed [CW-1:0] coord_type;
   // fields ordered min xyz, max xyz, origin xyz, dir xyz
   typedef struct {
      coord_type f [12];
   } ray_box_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   coord_type req_f [12] = '{default: '0};
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_hit;

   ray_box_type pending_tests[$];
   logic expected_hits[$];
   int errors = 0;
   int n_sent = 0;
   int n_hits = 0;
   int n_checked = 0;
   int idle_cycles = 0;
   bit stim_done = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   ray_box_slab_hit_test u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_box_min_x(req_f[0]), .req_box_min_y(req_f[1]), .req_box_min_z(req_f[2]),
      .req_box_max_x(req_f[3]), .req_box_max_y(req_f[4]), .req_box_max_z(req_f[5]),
      .req_ray_origin_x(req_f[6]), .req_ray_origin_y(req_f[7]),
      .req_ray_origin_z(req_f[8]),
      .req_ray_dir_x(req_f[9]), .req_ray_dir_y(req_f[10]), .req_ray_dir_z(req_f[11]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_hit(rsp_hit)
   );

   // Slab parameter: ((corner - origin) << FB) / dir, truncated toward zero.
   // The quotient fits well within 64 bits at these sizes, so no saturation.
   function automatic logic signed [127:0] slab_param(coord_type corner, coord_type origin,
                                                     coord_type dir);
      logic signed [127:0] num;
      num = (128'(signed'(corner)) - 128'(signed'(origin))) <<< FB;
      return num / 128'(signed'(dir));
   endfunction

   function automatic logic predict_hit(ray_box_type rb);
      logic signed [127:0] entry_t, exit_t, t0, t1, tmp;
      logic miss;
      entry_t = -(128'sd1 <<< 63);
      exit_t = (128'sd1 <<< 63) - 1;
      miss = 1'b0;
      for (int ax = 0; ax < 3; ax++) begin
         if (rb.f[9+ax] == 0) begin
            // flat direction: origin must sit strictly inside the slab
            if (!(rb.f[ax] < rb.f[6+ax] && rb.f[6+ax] < rb.f[3+ax])) miss = 1'b1;
         end else begin
            t0 = slab_param(rb.f[ax], rb.f[6+ax], rb.f[9+ax]);
            t1 = slab_param(rb.f[3+ax], rb.f[6+ax], rb.f[9+ax]);
            if (t1 < t0) begin
               tmp = t0; t0 = t1; t1 = tmp;
            end
            if (t0 > entry_t) entry_t = t0;
            if (t1 < exit_t) exit_t = t1;
         end
      end
      return !miss && (entry_t < exit_t);
   endfunction

   function automatic coord_type rand_coord(int mode);
      case (mode)
         0: return coord_type'($urandom);
         1: return coord_type'($urandom_range(0, 2 << FB)) - coord_type'(1 << FB);
         2: return coord_type'($urandom_range(0, 64 << FB)) - coord_type'(32 << FB);
         default: return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}}
                                              : {1'b1, {(CW-1){1'b0}}};
      endcase
   endfunction

   // Mostly well-formed boxes with rays aimed near them so hits are common.
   function automatic ray_box_type random_test();
      ray_box_type rb;
      int mode;
      coord_type a, b;
      mode = $urandom_range(0, 9);
      for (int ax = 0; ax < 3; ax++) begin
         if (mode == 0) begin
            for (int k = 0; k < 4; k++) rb.f[ax+3*k] = rand_coord($urandom_range(0, 3));
         end else begin
            a = rand_coord(2);
            b = rand_coord(2);
            rb.f[ax] = (mode == 1) ? b : ((a < b) ? a : b);
            rb.f[3+ax] = (mode == 1) ? a : ((a < b) ? b : a);
            rb.f[6+ax] = rand_coord($urandom_range(1, 2));
            case ($urandom_range(0, 7))
               0: rb.f[9+ax] = '0;
               1: rb.f[9+ax] = rand_coord(0);
               2: rb.f[9+ax] = rand_coord(3);
               default: rb.f[9+ax] = rand_coord(2);
            endcase
         end
      end
      return rb;
   endfunction

   function automatic ray_box_type make_test(coord_type mn, coord_type mx, coord_type o,
                                             coord_type d);
      ray_box_type rb;
      for (int ax = 0; ax < 3; ax++) begin
         rb.f[ax] = mn; rb.f[3+ax] = mx; rb.f[6+ax] = o; rb.f[9+ax] = d;
      end
      return rb;
   endfunction

   initial begin
      ray_box_type rb;
      coord_type one, cmax, cmin;
      one = coord_type'(1 << FB);
      cmax = {1'b0, {(CW-1){1'b1}}};
      cmin = {1'b1, {(CW-1){1'b0}}};
      // directed: plain hit, behind origin, all-flat inside/outside, edges
      pending_tests.push_back(make_test(-one, one, -4 * one, one));
      pending_tests.push_back(make_test(-one, one, 4 * one, one));
      pending_tests.push_back(make_test(-one, one, '0, '0));
      pending_tests.push_back(make_test(-one, one, one, '0));
      pending_tests.push_back(make_test(one, -one, '0, '0));
      pending_tests.push_back(make_test(one, -one, -4 * one, one));
      pending_tests.push_back(make_test(one, one, '0, one));
      pending_tests.push_back(make_test(cmin, cmax, cmin, 32'sd1));
      pending_tests.push_back(make_test(cmin, cmax, cmax, cmin));
      pending_tests.push_back(make_test(cmin, cmax, '0, cmax));
      pending_tests.push_back(make_test(cmax, cmin, cmin, -32'sd1));
      pending_tests.push_back(make_test(cmin, cmin, cmax, 32'sd1));
      pending_tests.push_back(make_test(-one, one, '0, -32'sd1));
      pending_tests.push_back(make_test('1, '1, '1, '1));
      // touching boxes: slabs meet at one t only
      rb = make_test('0, one, '0, one);
      rb.f[1] = one; rb.f[4] = 2 * one; rb.f[7] = '0; rb.f[10] = one;
      pending_tests.push_back(rb);
      // one flat axis outside, others hitting
      rb = make_test(-one, one, -4 * one, one);
      rb.f[10] = '0; rb.f[7] = 2 * one;
      pending_tests.push_back(rb);
      for (int i = 0; i < N_RANDOM; i++) pending_tests.push_back(random_test());
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // Drive the queue head; any beat taken in this step is already popped.
   task automatic rb_load();
      req_valid <= 1'b1;
      for (int k = 0; k < 12; k++) req_f[k] <= pending_tests[0].f[k];
   endtask

   // Sender: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_hits.push_back(predict_hit(pending_tests.pop_front()));
            n_sent++;
         end
         if (req_valid && !req_ready) begin
            // hold the beat until it is taken
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_tests.size() > 0) begin
            rb_load();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
            stim_done <= 1'b1;
         end
      end
   end

   // Receiver: stall pattern alternates between free running and random stalls.
   int stall_phase = 0;
   always @(posedge clock) begin
      stall_phase <= (stall_phase + 1) % 300;
      if (stall_phase < 100) rsp_ready <= 1'b1;
      else if (stall_phase < 200) rsp_ready <= ($urandom_range(0, 3) != 0);
      else rsp_ready <= ($urandom_range(0, 3) == 0);
   end

   // Monitor: compare each result beat with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_hits.size() == 0) begin
            $error("unexpected result beat: hit=%0b", rsp_hit);
            errors++;
         end else begin
            logic want;
            want = expected_hits.pop_front();
            if (rsp_hit !== want) begin
               $error("field hit: expected %0b, actual %0b", want, rsp_hit);
               errors++;
            end
            n_hits += want;
            n_checked++;
         end
      end
   end

   // Watchdog: count cycles with no beat taken on either side.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired: %0d results outstanding", expected_hits.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      wait (expected_hits.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      $display("covered %0d ray/box tests, %0d results checked, %0d hits", n_sent,
               n_checked, n_hits);
      if (errors == 0 && expected_hits.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire

[files.f]
rtl/core/rbsht_pkg.sv
rtl/core/rbsht_lane.sv
rtl/core/rbsht_merge.sv
rtl/core/ray_box_slab_hit_test.sv
rtl/core/rbsht_checker.sv
test/tb_top.sv
